// ----- rtl/core/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher block.
// Holds the microcode control word, status word and sequencer step codes.
// No dependencies; used by every module under rtl/core.
package rc4_pkg;

  // Byte and permutation table geometry
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  typedef logic [7:0] byte_t;

  // Key store geometry (1 .. 256 entries)
  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCW       = $clog2(KEY_DEPTH + 1);

  // Microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE = 4'd0;  // wait for a word, dispatch on it
  localparam step_t STEP_D0   = 4'd1;  // keystream: take S[i], read S[j]
  localparam step_t STEP_D1   = 4'd2;  // keystream: write S[i], read S[t]
  localparam step_t STEP_D2   = 4'd3;  // keystream: write S[j], emit result
  localparam step_t STEP_KI   = 4'd4;  // schedule: identity, clear indices
  localparam step_t STEP_K0   = 4'd5;  // schedule: read S[i]
  localparam step_t STEP_K1   = 4'd6;  // schedule: new j, read S[j]
  localparam step_t STEP_K2   = 4'd7;  // schedule: write S[i]
  localparam step_t STEP_K3   = 4'd8;  // schedule: write S[j], loop
  localparam step_t STEP_KE   = 4'd9;  // schedule: tidy up

  // Read address select for the permutation table
  typedef enum logic [2:0] {
    RA_I,    // i
    RA_I1,   // i + 1
    RA_JN,   // next j
    RA_T,    // a + S[j] just read
    RA_TR    // registered t
  } ra_sel_t;

  // Write select for the permutation table
  typedef enum logic [1:0] {
    WR_NONE,
    WR_I_RD,  // S[i] <= read data
    WR_J_A    // S[j] <= a
  } wr_sel_t;

  typedef enum logic [1:0] {
    J_HOLD,
    J_ZERO,
    J_ADD,      // j + read data
    J_ADD_KEY   // j + read data + key byte
  } j_op_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_ZERO,
    I_INC,
    I_INC_DATA  // increment only on an accepted data word
  } i_op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_OUT_BUSY,
    C_I_NOT_LAST
  } cond_t;

  // One microcode word
  typedef struct packed {
    ra_sel_t ra_sel;
    wr_sel_t wr_sel;
    j_op_t   j_op;
    i_op_t   i_op;
    logic    accept;
    logic    dispatch;
    logic    load_a;
    logic    load_bt;
    logic    clear_perm;
    logic    key_adv;
    logic    key_clear;
    logic    count_clear;
    logic    emit;
    cond_t   cond;
    step_t   tgt_t;
    step_t   tgt_f;
  } cw_t;

  localparam cw_t CW_NOP = '{
    ra_sel:      RA_I,
    wr_sel:      WR_NONE,
    j_op:        J_HOLD,
    i_op:        I_HOLD,
    accept:      1'b0,
    dispatch:    1'b0,
    load_a:      1'b0,
    load_bt:     1'b0,
    clear_perm:  1'b0,
    key_adv:     1'b0,
    key_clear:   1'b0,
    count_clear: 1'b0,
    emit:        1'b0,
    cond:        C_ALWAYS,
    tgt_t:       STEP_IDLE,
    tgt_f:       STEP_IDLE
  };

  // Datapath status back to the sequencer
  typedef struct packed {
    logic out_busy;
    logic i_last;
  } stat_t;

endpackage

// ----- rtl/core/rc4_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on rc4_pkg for the control word, status word and step codes.
module rc4_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          in_func,
  input  logic          in_key_last,
  input  rc4_pkg::stat_t stat,
  output rc4_pkg::cw_t   ctrl
);

  rc4_pkg::step_t step_r;
  rc4_pkg::step_t step_nxt;
  rc4_pkg::cw_t   cw;
  logic           cond_hit;

  // Control ROM
  always_comb begin
    cw = rc4_pkg::CW_NOP;
    unique case (step_r)
      rc4_pkg::STEP_IDLE: begin
        cw.accept   = 1'b1;
        cw.dispatch = 1'b1;
        cw.i_op     = rc4_pkg::I_INC_DATA;
        cw.ra_sel   = rc4_pkg::RA_I1;
      end
      rc4_pkg::STEP_D0: begin
        cw.load_a = 1'b1;
        cw.j_op   = rc4_pkg::J_ADD;
        cw.ra_sel = rc4_pkg::RA_JN;
        cw.tgt_t  = rc4_pkg::STEP_D1;
      end
      rc4_pkg::STEP_D1: begin
        cw.wr_sel  = rc4_pkg::WR_I_RD;
        cw.load_bt = 1'b1;
        cw.ra_sel  = rc4_pkg::RA_T;
        cw.tgt_t   = rc4_pkg::STEP_D2;
      end
      rc4_pkg::STEP_D2: begin
        cw.wr_sel = rc4_pkg::WR_J_A;
        cw.ra_sel = rc4_pkg::RA_TR;
        cw.emit   = 1'b1;
        cw.cond   = rc4_pkg::C_OUT_BUSY;
        cw.tgt_t  = rc4_pkg::STEP_D2;
        cw.tgt_f  = rc4_pkg::STEP_IDLE;
      end
      rc4_pkg::STEP_KI: begin
        cw.clear_perm = 1'b1;
        cw.i_op       = rc4_pkg::I_ZERO;
        cw.j_op       = rc4_pkg::J_ZERO;
        cw.key_clear  = 1'b1;
        cw.tgt_t      = rc4_pkg::STEP_K0;
      end
      rc4_pkg::STEP_K0: begin
        cw.ra_sel = rc4_pkg::RA_I;
        cw.tgt_t  = rc4_pkg::STEP_K1;
      end
      rc4_pkg::STEP_K1: begin
        cw.load_a = 1'b1;
        cw.j_op   = rc4_pkg::J_ADD_KEY;
        cw.ra_sel = rc4_pkg::RA_JN;
        cw.tgt_t  = rc4_pkg::STEP_K2;
      end
      rc4_pkg::STEP_K2: begin
        cw.wr_sel = rc4_pkg::WR_I_RD;
        cw.tgt_t  = rc4_pkg::STEP_K3;
      end
      rc4_pkg::STEP_K3: begin
        cw.wr_sel  = rc4_pkg::WR_J_A;
        cw.i_op    = rc4_pkg::I_INC;
        cw.key_adv = 1'b1;
        cw.cond    = rc4_pkg::C_I_NOT_LAST;
        cw.tgt_t   = rc4_pkg::STEP_K0;
        cw.tgt_f   = rc4_pkg::STEP_KE;
      end
      rc4_pkg::STEP_KE: begin
        cw.i_op        = rc4_pkg::I_ZERO;
        cw.j_op        = rc4_pkg::J_ZERO;
        cw.count_clear = 1'b1;
        cw.tgt_t       = rc4_pkg::STEP_IDLE;
      end
      default: cw = rc4_pkg::CW_NOP;
    endcase
  end

  assign ctrl = cw;

  // Jump condition
  always_comb begin
    unique case (cw.cond)
      rc4_pkg::C_ALWAYS:     cond_hit = 1'b1;
      rc4_pkg::C_OUT_BUSY:   cond_hit = stat.out_busy;
      rc4_pkg::C_I_NOT_LAST: cond_hit = !stat.i_last;
      default:               cond_hit = 1'b1;
    endcase
  end

  // Next step: dispatch on the incoming word, else take the jump
  always_comb begin
    if (cw.dispatch) begin
      if (!accept) begin
        step_nxt = rc4_pkg::STEP_IDLE;
      end else if (in_func) begin
        step_nxt = rc4_pkg::STEP_D0;
      end else if (in_key_last) begin
        step_nxt = rc4_pkg::STEP_KI;
      end else begin
        step_nxt = rc4_pkg::STEP_IDLE;
      end
    end else begin
      step_nxt = cond_hit ? cw.tgt_t : cw.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rc4_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/rc4_perm_store.sv -----
// Permutation table S: 256 bytes, one read and one write port, read data
// registered. Per-entry valid bits give the identity value until written.
// Depends on rc4_pkg for geometry.
module rc4_perm_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear_all,
  input  logic [rc4_pkg::PERM_AW-1:0]   rd_addr,
  output rc4_pkg::byte_t                rd_data,
  input  logic                          wr_en,
  input  logic [rc4_pkg::PERM_AW-1:0]   wr_addr,
  input  rc4_pkg::byte_t                wr_data
);

  rc4_pkg::byte_t                  mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0]  vld_r;
  rc4_pkg::byte_t                  raw_r;
  logic                            hit_r;
  logic [rc4_pkg::PERM_AW-1:0]     addr_r;

  // Storage and registered read (old data on a same-address write)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    raw_r  <= mem[rd_addr];
    hit_r  <= vld_r[rd_addr];
    addr_r <= rd_addr;
  end

  // Valid bits: cleared at once by reset or by a fresh schedule
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear_all) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Unwritten entry reads as its own index
  assign rd_data = hit_r ? raw_r : rc4_pkg::byte_t'(addr_r);

endmodule

// ----- rtl/core/rc4_datapath.sv -----
// Datapath: indices i and j, key store, swap registers and output register.
// Driven word by word from the microcode; uses rc4_perm_store and rc4_pkg.
module rc4_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  rc4_pkg::cw_t   ctrl,
  input  logic           accept,
  input  logic           in_func,
  input  rc4_pkg::byte_t in_byte,
  input  logic           out_stall,
  output logic           out_valid,
  output rc4_pkg::byte_t out_byte,
  output rc4_pkg::stat_t stat
);

  localparam int KAW = rc4_pkg::KEY_AW;
  localparam int KCW = rc4_pkg::KCW;

  rc4_pkg::byte_t i_r, i_nxt;
  rc4_pkg::byte_t j_r, j_nxt;
  rc4_pkg::byte_t a_r, b_r, t_r, byte_r;
  rc4_pkg::byte_t s_rd, ra, t_sum, ks;
  logic           s_we;
  rc4_pkg::byte_t s_wa, s_wd;

  rc4_pkg::byte_t key_mem [rc4_pkg::KEY_DEPTH];
  rc4_pkg::byte_t key_rd_r;
  logic [KAW-1:0] kpos_r, kpos_nxt;
  logic [KCW:0]   kpos_inc;
  logic [KCW-1:0] count_r, count_nxt;
  logic           key_room, key_wr;

  logic           out_valid_r;
  rc4_pkg::byte_t out_byte_r;
  logic           out_busy;

  // Permutation table
  rc4_perm_store u_perm (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (ctrl.clear_perm),
    .rd_addr   (ra),
    .rd_data   (s_rd),
    .wr_en     (s_we),
    .wr_addr   (s_wa),
    .wr_data   (s_wd)
  );

  // Index updates
  always_comb begin
    unique case (ctrl.j_op)
      rc4_pkg::J_HOLD:    j_nxt = j_r;
      rc4_pkg::J_ZERO:    j_nxt = '0;
      rc4_pkg::J_ADD:     j_nxt = j_r + s_rd;
      rc4_pkg::J_ADD_KEY: j_nxt = j_r + s_rd + key_rd_r;
      default:            j_nxt = j_r;
    endcase
    unique case (ctrl.i_op)
      rc4_pkg::I_HOLD:     i_nxt = i_r;
      rc4_pkg::I_ZERO:     i_nxt = '0;
      rc4_pkg::I_INC:      i_nxt = i_r + 8'd1;
      rc4_pkg::I_INC_DATA: i_nxt = (accept && in_func) ? i_r + 8'd1 : i_r;
      default:             i_nxt = i_r;
    endcase
  end

  // Table read address
  assign t_sum = a_r + s_rd;
  always_comb begin
    unique case (ctrl.ra_sel)
      rc4_pkg::RA_I:  ra = i_r;
      rc4_pkg::RA_I1: ra = i_r + 8'd1;
      rc4_pkg::RA_JN: ra = j_nxt;
      rc4_pkg::RA_T:  ra = t_sum;
      rc4_pkg::RA_TR: ra = t_r;
      default:        ra = i_r;
    endcase
  end

  // Table write: one half of the swap per step
  always_comb begin
    s_we = 1'b0;
    s_wa = i_r;
    s_wd = s_rd;
    unique case (ctrl.wr_sel)
      rc4_pkg::WR_NONE: s_we = 1'b0;
      rc4_pkg::WR_I_RD: begin
        s_we = 1'b1;
        s_wa = i_r;
        s_wd = s_rd;
      end
      rc4_pkg::WR_J_A: begin
        s_we = 1'b1;
        s_wa = j_r;
        s_wd = a_r;
      end
      default: s_we = 1'b0;
    endcase
  end

  // Keystream byte; S[t] was read while S[i] was being written
  always_comb begin
    if (t_r == j_r) begin
      ks = a_r;
    end else if (t_r == i_r) begin
      ks = b_r;
    end else begin
      ks = s_rd;
    end
  end

  // Key position and fill count
  assign key_room = count_r < KCW'(rc4_pkg::KEY_DEPTH);
  assign key_wr   = accept && !in_func && key_room;
  assign kpos_inc = {{(KCW + 1 - KAW){1'b0}}, kpos_r} + (KCW + 1)'(1);

  always_comb begin
    kpos_nxt = kpos_r;
    if (ctrl.key_clear) begin
      kpos_nxt = '0;
    end else if (ctrl.key_adv) begin
      kpos_nxt = (kpos_inc >= {1'b0, count_r}) ? '0 : kpos_inc[KAW-1:0];
    end
    count_nxt = count_r;
    if (ctrl.count_clear) begin
      count_nxt = '0;
    end else if (key_wr) begin
      count_nxt = count_r + KCW'(1);
    end
  end

  // Key store
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[count_r[KAW-1:0]] <= in_byte;
    end
    key_rd_r <= key_mem[kpos_r];
  end

  // Output register
  assign out_busy = out_valid_r && out_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      kpos_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      kpos_r  <= kpos_nxt;
      count_r <= count_nxt;
      if (ctrl.emit && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
    if (ctrl.load_a) begin
      a_r <= s_rd;
    end
    if (ctrl.load_bt) begin
      b_r <= s_rd;
      t_r <= t_sum;
    end
    if (ctrl.emit && !out_busy) begin
      out_byte_r <= byte_r ^ ks;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign stat.out_busy = out_busy;
  assign stat.i_last   = (i_r == 8'hFF);

endmodule

// ----- rtl/core/rc4_stream_cipher.sv -----
// RC4 stream cipher top level: microcoded sequencer plus datapath.
// Key word: taken in the idle step, which stays ready for the next.
// Data word: no new word until the 3-step swap on the single-write-port
// permutation table is done; result registered in its last step, held
// while the output stalls. Last key word: four steps for each of 256 swaps.
// Reset (rst_n, synchronous): identity permutation, i = j = 0, no key held.
module rc4_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_byte_in,
  input  logic       in_key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out
);

  rc4_pkg::cw_t   ctrl;
  rc4_pkg::stat_t stat;
  logic           accept;

  // Input handshake: words are taken only in the idle step
  assign in_stall = !ctrl.accept;
  assign accept   = in_valid && ctrl.accept;

  rc4_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_func     (in_func),
    .in_key_last (in_key_last),
    .stat        (stat),
    .ctrl        (ctrl)
  );

  rc4_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .accept    (accept),
    .in_func   (in_func),
    .in_byte   (in_byte_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte_out),
    .stat      (stat)
  );

endmodule
